FILE: design/laser_line_row_centroid_top_macros.svh
// ---------------------------------------------------------------------------
// Laser line row centroid assertion macros
// Shared concurrent assertion forms used by the top level.
// ---------------------------------------------------------------------------
`ifndef LASER_LINE_ROW_CENTROID_TOP_MACROS_SVH
`define LASER_LINE_ROW_CENTROID_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LLRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LLRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LLRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define LLRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: design/llrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Laser line row centroid package
// Request types, run job type and shared constants.
// ---------------------------------------------------------------------------
package llrc_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int PIX_W     = 8;
    localparam int RUN_W     = 12;
    localparam int WSUM_W    = 31;
    localparam int ISUM_W    = 19;
    localparam int CENTER_W  = 15;
    localparam int ROW_IDX_W = 11;
    localparam int FRAC_W    = 4;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [RUN_W-1:0] MIN_RUN_RESET = RUN_W'(3);

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             in_mask;
        logic             row_end;
        logic             frame_start;
    } llrc_pixel_t;

    typedef struct packed {
        logic [CENTER_W-1:0]  center_x_q4;
        logic [ROW_IDX_W-1:0] row_index;
    } llrc_result_t;

    typedef struct packed {
        logic [WSUM_W-1:0]    wsum;
        logic [ISUM_W-1:0]    isum;
        logic [ROW_IDX_W-1:0] row;
    } llrc_job_t;

endpackage
`default_nettype wire

FILE: design/llrc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Laser line row centroid front end
// Tracks column and row, accumulates masked runs, pushes qualifying runs to the job queue.
// ---------------------------------------------------------------------------
module llrc_front
    import llrc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         take,
    input  wire llrc_pixel_t  pixel,
    input  wire logic         cfg_wr,
    input  wire logic [RUN_W-1:0] cfg_data,
    output logic              job_push,
    output llrc_job_t         job
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [CW-1:0] COL_LAST = CW'(MAX_WIDTH - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(MAX_HEIGHT - 1);

    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [RUN_W-1:0]  len_reg, len_next;
    logic [WSUM_W-1:0] wsum_reg, wsum_next;
    logic [ISUM_W-1:0] isum_reg, isum_next;
    logic [RUN_W-1:0]  min_len_reg, min_len_next;

    logic [CW-1:0]     col_cur;
    logic [RW-1:0]     row_cur;
    logic [RUN_W-1:0]  len_cur, len_acc, len_cls;
    logic [WSUM_W-1:0] wsum_cur, wsum_acc, wsum_cls;
    logic [ISUM_W-1:0] isum_cur, isum_acc, isum_cls;
    logic [CW+PIX_W-1:0] prod;
    logic [WSUM_W:0]   wsum_sum;
    logic [ISUM_W:0]   isum_sum;
    logic              closing;

    always_comb
    begin
        col_cur  = pixel.frame_start ? '0 : col_reg;
        row_cur  = pixel.frame_start ? '0 : row_reg;
        len_cur  = pixel.frame_start ? '0 : len_reg;
        wsum_cur = pixel.frame_start ? '0 : wsum_reg;
        isum_cur = pixel.frame_start ? '0 : isum_reg;

        prod     = (CW+PIX_W)'(col_cur) * (CW+PIX_W)'(pixel.pixel_value);
        wsum_sum = {1'b0, wsum_cur} + (WSUM_W+1)'(prod);
        isum_sum = {1'b0, isum_cur} + (ISUM_W+1)'(pixel.pixel_value);
        len_acc  = (len_cur == '1) ? len_cur : len_cur + RUN_W'(1);
        wsum_acc = wsum_sum[WSUM_W] ? '1 : wsum_sum[WSUM_W-1:0];
        isum_acc = isum_sum[ISUM_W] ? '1 : isum_sum[ISUM_W-1:0];

        len_cls  = pixel.in_mask ? len_acc  : len_cur;
        wsum_cls = pixel.in_mask ? wsum_acc : wsum_cur;
        isum_cls = pixel.in_mask ? isum_acc : isum_cur;
        closing  = !pixel.in_mask || pixel.row_end;

        job_push = take && closing && (len_cls >= min_len_reg) && (isum_cls != '0);
        job.wsum = wsum_cls;
        job.isum = isum_cls;
        job.row  = ROW_IDX_W'(row_cur);

        col_next     = col_reg;
        row_next     = row_reg;
        len_next     = len_reg;
        wsum_next    = wsum_reg;
        isum_next    = isum_reg;
        min_len_next = cfg_wr ? cfg_data : min_len_reg;

        if (take)
        begin
            if (closing)
            begin
                len_next  = '0;
                wsum_next = '0;
                isum_next = '0;
            end
            else
            begin
                len_next  = len_acc;
                wsum_next = wsum_acc;
                isum_next = isum_acc;
            end
            if (pixel.row_end)
            begin
                col_next = '0;
                row_next = (row_cur == ROW_LAST) ? '0 : row_cur + RW'(1);
            end
            else
            begin
                col_next = (col_cur == COL_LAST) ? '0 : col_cur + CW'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            len_reg     <= '0;
            wsum_reg    <= '0;
            isum_reg    <= '0;
            min_len_reg <= MIN_RUN_RESET;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            len_reg     <= len_next;
            wsum_reg    <= wsum_next;
            isum_reg    <= isum_next;
            min_len_reg <= min_len_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/llrc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Laser line row centroid job queue
// Short register queue between the run accumulator and the divider.
// ---------------------------------------------------------------------------
module llrc_queue
    import llrc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire llrc_job_t wr_data,
    input  wire logic      rd_en,
    output llrc_job_t      rd_data,
    output logic           is_full,
    output logic           is_empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

    llrc_job_t       mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        is_full     = (cnt_reg == NW'(QUEUE_DEPTH));
        is_empty    = (cnt_reg == '0);
        rd_data     = mem_reg[rd_ptr_reg];
        wr_ptr_next = wr_en ? ((wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1))
                            : wr_ptr_reg;
        rd_ptr_next = rd_en ? ((rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1))
                            : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/llrc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Laser line row centroid back end
// Bit-serial divider for the weighted centre and the result register.
// ---------------------------------------------------------------------------
module llrc_back
    import llrc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      job_empty,
    input  wire llrc_job_t job,
    output logic           job_pop,
    input  wire logic      pop,
    output logic           empty,
    output llrc_result_t   result
);

    localparam int SW = $clog2(CENTER_W);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HOLD} state_t;

    state_t              state_reg, state_next;
    logic [ISUM_W-1:0]   rem_reg, rem_next;
    logic [ISUM_W-1:0]   div_reg, div_next;
    logic [CENTER_W-1:0] num_reg, num_next;
    logic [CENTER_W-1:0] quo_reg, quo_next;
    logic [ROW_IDX_W-1:0] row_reg, row_next;
    logic [SW-1:0]       cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    llrc_result_t        out_reg, out_next;

    logic [ISUM_W:0]     shifted;
    logic [ISUM_W+1:0]   diff;
    logic                fits;

    always_comb
    begin
        shifted = {rem_reg, num_reg[CENTER_W-1]};
        diff    = {1'b0, shifted} - {2'b00, div_reg};
        fits    = !diff[ISUM_W+1];

        state_next     = state_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        job_pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop  = 1'b1;
                    div_next = job.isum;
                    row_next = job.row;
                    rem_next = ISUM_W'(job.wsum[WSUM_W-1:CENTER_W-FRAC_W]);
                    num_next = {job.wsum[CENTER_W-FRAC_W-1:0], FRAC_W'(0)};
                    cnt_next = SW'(CENTER_W - 1);
                    quo_next = '0;
                    if (job.wsum >= WSUM_W'({job.isum, (CENTER_W-FRAC_W)'(0)}))
                    begin
                        quo_next   = '1;
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = fits ? diff[ISUM_W-1:0] : shifted[ISUM_W-1:0];
                num_next = {num_reg[CENTER_W-2:0], 1'b0};
                quo_next = {quo_reg[CENTER_W-2:0], fits};
                cnt_next = cnt_reg - SW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next.center_x_q4 = quo_reg;
                    out_next.row_index   = row_reg;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rem_reg       <= '0;
            div_reg       <= '0;
            num_reg       <= '0;
            quo_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            div_reg       <= div_next;
            num_reg       <= num_next;
            quo_reg       <= quo_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule
`default_nettype wire

FILE: design/laser_line_row_centroid_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a closing pixel is written into the four-entry job queue; the back end pops the job, divides it
//   bit-serially in ST_DIV (skipped when the centre clamps), then loads the result register in ST_HOLD.
// Throughput: one pixel per cycle while full is low; the divider takes one emitted run at a time,
//   so full rises when closed runs arrive faster than the divider and pop drain them.
// Reset: rst_n clears column, row and run sums, empties the queue, sets min_run_length to 3.
// ---------------------------------------------------------------------------
// Laser line row centroid top level
// Per-row laser run detection with intensity-weighted centre column.
// ---------------------------------------------------------------------------
`include "laser_line_row_centroid_top_macros.svh"

module laser_line_row_centroid_top
    import llrc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire llrc_pixel_t      pixel,
    output logic                  empty,
    input  wire logic             pop,
    output llrc_result_t          result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [RUN_W-1:0] cfg_data
);

    logic      take;
    logic      job_push;
    logic      job_pop;
    logic      job_full;
    logic      job_empty;
    llrc_job_t job_in;
    llrc_job_t job_out;

    assign full      = job_full;
    assign take      = push && !job_full;
    assign cfg_ready = 1'b1;

    llrc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .pixel    (pixel),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .job_push (job_push),
        .job      (job_in)
    );

    llrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_data  (job_in),
        .rd_en    (job_pop),
        .rd_data  (job_out),
        .is_full  (job_full),
        .is_empty (job_empty)
    );

    llrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    `LLRC_ASSERT_IMP(a_push_room, clk, rst_n, job_push, !job_full, "job pushed into full queue")
    `LLRC_ASSERT_IMP(a_pop_data, clk, rst_n, job_pop, !job_empty, "job popped from empty queue")
    `LLRC_ASSERT_IMP(a_full_nonempty, clk, rst_n, job_full, !job_empty, "queue full and empty")
    `LLRC_ASSERT_NXT(a_result_held, clk, rst_n, !empty && !pop, !empty, "result dropped")

endmodule
`default_nettype wire

FILE: test/laser_line_row_centroid_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Laser line row centroid checker
// Watches the pixel, result and configuration channels of the row centroid
// block, keeps its own copy of the run accumulators, predicts the centre of
// every qualifying run and compares each popped result against the oldest
// prediction. Reports the number of mismatches and of outstanding centroids.
// ---------------------------------------------------------------------------
module laser_line_row_centroid_checker
    import llrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  llrc_pixel_t      pixel,
    input  logic             empty,
    input  logic             pop,
    input  llrc_result_t     result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [RUN_W-1:0] cfg_data,
    output int               mismatches,
    output int               pending
);

    localparam longint unsigned RUN_MAX    = (64'd1 << RUN_W) - 1;
    localparam longint unsigned WSUM_MAX   = (64'd1 << WSUM_W) - 1;
    localparam longint unsigned ISUM_MAX   = (64'd1 << ISUM_W) - 1;
    localparam longint unsigned CENTER_MAX = (64'd1 << CENTER_W) - 1;

    logic [RUN_W-1:0]     min_run;
    logic [ROW_IDX_W-1:0] column;
    logic [ROW_IDX_W-1:0] row;
    logic [RUN_W-1:0]     run_len;
    logic [WSUM_W-1:0]    wsum;
    logic [ISUM_W-1:0]    isum;
    llrc_result_t         centroid_q[$];
    llrc_result_t         predicted;
    llrc_result_t         oldest;
    bit                   emitted;

    function automatic void clear_run();
        run_len = '0;
        wsum    = '0;
        isum    = '0;
    endfunction

    function automatic bit close_run(output llrc_result_t r);
        longint unsigned lw;
        longint unsigned li;
        longint unsigned q;
        bit              hit;
        hit = 1'b0;
        r   = '0;
        if (run_len >= min_run && isum != '0) begin
            lw = wsum;
            li = isum;
            q  = (lw * 16) / li;
            if (q > CENTER_MAX)
                q = CENTER_MAX;
            r.center_x_q4 = CENTER_W'(q);
            r.row_index   = row;
            hit = 1'b1;
        end
        clear_run();
        return hit;
    endfunction

    function automatic bit predict_pixel(input llrc_pixel_t p, output llrc_result_t r);
        longint unsigned w;
        longint unsigned s;
        bit              hit;
        hit = 1'b0;
        r   = '0;
        if (p.frame_start) begin
            column = '0;
            row    = '0;
            clear_run();
        end
        if (p.in_mask) begin
            w = wsum;
            w = w + column * p.pixel_value;
            s = isum;
            s = s + p.pixel_value;
            if (run_len < RUN_MAX)
                run_len = run_len + 1'b1;
            wsum = (w > WSUM_MAX) ? WSUM_W'(WSUM_MAX) : WSUM_W'(w);
            isum = (s > ISUM_MAX) ? ISUM_W'(ISUM_MAX) : ISUM_W'(s);
            if (p.row_end)
                hit = close_run(r);
        end
        else begin
            hit = close_run(r);
        end
        if (p.row_end) begin
            clear_run();
            column = '0;
            row    = ROW_IDX_W'((int'(row) + 1) % DEF_MAX_HEIGHT);
        end
        else begin
            column = ROW_IDX_W'((int'(column) + 1) % DEF_MAX_WIDTH);
        end
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_run = MIN_RUN_RESET;
            column  = '0;
            row     = '0;
            clear_run();
            centroid_q.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (centroid_q.size() == 0)
                begin
                    $error("unexpected result: center_x_q4 %0d row_index %0d",
                           result.center_x_q4, result.row_index);
                    mismatches++;
                end
                else
                begin
                    oldest = centroid_q.pop_front();
                    if (result.center_x_q4 !== oldest.center_x_q4)
                    begin
                        $error("center_x_q4: expected %0d, actual %0d",
                               oldest.center_x_q4, result.center_x_q4);
                        mismatches++;
                    end
                    if (result.row_index !== oldest.row_index)
                    begin
                        $error("row_index: expected %0d, actual %0d",
                               oldest.row_index, result.row_index);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                min_run = cfg_data;
            if (push && !full)
            begin
                emitted = predict_pixel(pixel, predicted);
                if (emitted)
                    centroid_q = {centroid_q, predicted};
            end
            pending = centroid_q.size();
        end
    end

endmodule

FILE: test/tb_laser_line_row_centroid_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Laser line row centroid testbench
// Drives pixel rows and threshold settings into the block with random gaps
// on both sides: short directed runs, thresholds near the maximum row width
// and random frames, with the checker beside it.
// ---------------------------------------------------------------------------
module tb_laser_line_row_centroid_top;
    import llrc_pkg::*;

    localparam int DRAIN_CYCLES = 100;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             push;
    logic             full;
    llrc_pixel_t      pixel;
    logic             empty;
    logic             pop;
    llrc_result_t     result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [RUN_W-1:0] cfg_data;
    logic             no_stall;
    int               mismatches;
    int               pending;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    laser_line_row_centroid_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    laser_line_row_centroid_checker u_centroid_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel      (pixel),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= no_stall || ($urandom_range(0, 99) >= 9);
    end

    function automatic logic [PIX_W-1:0] rand_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input llrc_pixel_t p);
        while (!no_stall && $urandom_range(0, 99) < 9)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_run(input int count, input logic [PIX_W-1:0] level);
        for (int i = 0; i < count; i++)
            send_pixel(llrc_pixel_t'{level, 1'b1, 1'b0, 1'b0});
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_min_run(input logic [RUN_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_frames(input int count, input int max_len);
        int          sent;
        int          rows;
        int          len;
        bit          masked;
        llrc_pixel_t p;
        sent = 0;
        while (sent < count)
        begin
            rows = $urandom_range(1, 6);
            for (int r = 0; r < rows && sent < count; r++)
            begin
                len    = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, max_len);
                masked = $urandom_range(0, 1);
                for (int c = 0; c < len; c++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        masked = !masked;
                    p.pixel_value = rand_level();
                    p.in_mask     = masked;
                    p.row_end     = (c == len - 1);
                    p.frame_start = (r == 0 && c == 0);
                    // inject a broken pixel now and then
                    if ($urandom_range(0, 19) == 0)
                        p = llrc_pixel_t'(11'($urandom));
                    send_pixel(p);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        push      <= 1'b0;
        pixel     <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        no_stall  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset threshold: qualifying, short, dark, row-end and frame-start runs
        send_pixel(llrc_pixel_t'{8'd0,   1'b0, 1'b0, 1'b1});
        send_run(3, 8'd255);
        send_pixel(llrc_pixel_t'{8'd0,   1'b0, 1'b0, 1'b0});
        send_pixel(llrc_pixel_t'{8'd10,  1'b1, 1'b0, 1'b0});
        send_pixel(llrc_pixel_t'{8'd20,  1'b1, 1'b0, 1'b0});
        send_pixel(llrc_pixel_t'{8'd99,  1'b0, 1'b0, 1'b0});
        send_run(3, 8'd0);
        send_pixel(llrc_pixel_t'{8'd255, 1'b0, 1'b0, 1'b0});
        send_pixel(llrc_pixel_t'{8'd1,   1'b1, 1'b0, 1'b0});
        send_pixel(llrc_pixel_t'{8'd200, 1'b1, 1'b0, 1'b0});
        send_pixel(llrc_pixel_t'{8'd7,   1'b1, 1'b1, 1'b0});
        send_pixel(llrc_pixel_t'{8'd50,  1'b1, 1'b0, 1'b0});
        send_pixel(llrc_pixel_t'{8'd60,  1'b1, 1'b0, 1'b0});
        send_pixel(llrc_pixel_t'{8'd70,  1'b1, 1'b0, 1'b0});
        send_pixel(llrc_pixel_t'{8'd80,  1'b1, 1'b0, 1'b1});
        send_pixel(llrc_pixel_t'{8'd90,  1'b1, 1'b0, 1'b0});
        send_pixel(llrc_pixel_t'{8'd255, 1'b1, 1'b1, 1'b0});
        send_pixel(llrc_pixel_t'{8'd128, 1'b0, 1'b1, 1'b0});

        set_min_run(RUN_W'(0));
        send_pixel(llrc_pixel_t'{8'd0,   1'b1, 1'b1, 1'b0});
        send_pixel(llrc_pixel_t'{8'd5,   1'b1, 1'b1, 1'b0});
        send_pixel(llrc_pixel_t'{8'd33,  1'b0, 1'b0, 1'b0});
        send_pixel(llrc_pixel_t'{8'd33,  1'b0, 1'b1, 1'b0});

        // thresholds near the maximum row width
        set_min_run(RUN_W'(2047));
        send_pixel(llrc_pixel_t'{8'd0, 1'b0, 1'b1, 1'b1});
        send_run(6, 8'd200);
        send_pixel(llrc_pixel_t'{8'd0, 1'b0, 1'b1, 1'b0});
        set_min_run(RUN_W'(2048));
        send_run(6, 8'd200);
        send_pixel(llrc_pixel_t'{8'd255, 1'b1, 1'b1, 1'b0});

        for (int k = 0; k < 5; k++)
        begin
            set_min_run((k == 0) ? RUN_W'(0) : RUN_W'($urandom_range(0, 6)));
            no_stall <= (k == 2);
            random_frames(160, 40);
        end
        no_stall <= 1'b0;

        drain();
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
